/* rtl/glzw_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package glzw_pkg;
    localparam int CODE_BITS = 12;
    localparam int DICT_DEPTH = 4096;
    localparam int BUF_BITS = 20;

    localparam logic [1:0] FUNC_PUSH = 2'd0;
    localparam logic [1:0] FUNC_PULL = 2'd1;
    localparam logic [1:0] FUNC_RESTART = 2'd2;

    localparam logic [2:0] ST_PIXEL = 3'd0;
    localparam logic [2:0] ST_NEED = 3'd1;
    localparam logic [2:0] ST_END = 3'd2;
    localparam logic [2:0] ST_TRUNC = 3'd3;
    localparam logic [2:0] ST_ACCEPT = 3'd4;
    localparam logic [2:0] ST_REJECT = 3'd5;

    localparam logic CFG_MIN_CODE = 1'b0;
    localparam logic CFG_LINE_WIDTH = 1'b1;

    localparam logic [1:0] PH_NORMAL = 2'd0;
    localparam logic [1:0] PH_FIRST = 2'd1;
    localparam logic [1:0] PH_ENDED = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic restart;
        logic push;        // perform push_byte
        logic pop_req;     // read stack top
        logic pop_done;    // deliver popped pixel
        logic extract;     // cut code and classify
        logic dec_start;   // begin decode of latched code
        logic walk_step;   // consume dict data
        logic dec_finish;  // final push and table update
        logic emit_status; // output with status_sel
        logic [2:0] status_sel;
    } glzw_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [1:0] phase;
        logic stack_empty;
        logic enough_bits;
        logic code_is_end;
        logic code_is_clear;
        logic walk_more;
        logic data_ended;
    } glzw_sts_t;
endpackage
`default_nettype wire

/* rtl/gif_lzw_decoder.sv */
// Push words: result registered in the cycle after accept; restart and unused func words give no result.
// Pull: stacked pixel via S_PULL (pop request) and S_POP; status answer from S_PULL. A code
// cut runs S_PULL and S_CODE, a data code S_WCHK, a chain step S_WREQ (read), S_WSTEP (stack write).
// Throughput: one word at a time, next accepted the cycle after the result is taken.
// Reset (rst_n, async low): registers to defaults, min_code_size 8, line_width 640;
// dictionary and pixel stack RAMs are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module gif_lzw_decoder (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,  // data_byte[7:0]
    input  wire logic [1:0]  s_axis_tuser,  // func[1:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,  // pixel[7:0], partial[23:8], bad_total[39:24]
    output logic [2:0]       m_axis_tuser,  // status[2:0]
    output logic             m_axis_tlast   // row_end
);
    glzw_pkg::glzw_cmd_t cmd;
    glzw_pkg::glzw_sts_t sts;
    logic        out_load;
    logic        valid_reg;
    logic        in_fire;
    logic [7:0]  pixel;
    logic [2:0]  status;
    logic        row_end;
    logic [15:0] partial_row_pixels;
    logic [15:0] bad_code_total;

    assign in_fire = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata = {bad_code_total, partial_row_pixels, pixel};
    assign m_axis_tuser = status;
    assign m_axis_tlast = row_end;

    glzw_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .func(s_axis_tuser),
        .out_busy(valid_reg), .in_ready(s_axis_tready), .out_load(out_load),
        .sts(sts), .cmd(cmd)
    );

    glzw_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .cmd(cmd), .data_byte(s_axis_tdata), .sts(sts),
        .pixel(pixel), .status(status), .row_end(row_end),
        .partial_row_pixels(partial_row_pixels), .bad_code_total(bad_code_total)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) valid_reg <= 1'b0;
        else if (out_load) valid_reg <= 1'b1;
        else if (m_axis_tready) valid_reg <= 1'b0;
    end
endmodule
`default_nettype wire

/* rtl/glzw_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
module glzw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]              rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

/* rtl/glzw_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
module glzw_datapath (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire logic                cfg_index,
    input  wire logic [15:0]         cfg_data,
    input  wire glzw_pkg::glzw_cmd_t cmd,
    input  wire logic [7:0]          data_byte,
    output glzw_pkg::glzw_sts_t      sts,
    output logic [7:0]               pixel,
    output logic [2:0]               status,
    output logic                     row_end,
    output logic [15:0]              partial_row_pixels,
    output logic [15:0]              bad_code_total
);
    logic [3:0]  min_code_reg;
    logic [15:0] line_width_reg;
    logic [12:0] stack_depth_reg;
    logic [19:0] bit_buffer_reg;
    logic [4:0]  bit_count_reg;
    logic [7:0]  block_remaining_reg;
    logic [3:0]  code_width_reg;
    logic [12:0] next_slot_reg;
    logic [12:0] slot_limit_reg;
    logic [11:0] previous_code_reg;
    logic [7:0]  first_pixel_reg;
    logic [15:0] row_left_reg;
    logic [15:0] bad_codes_reg;
    logic [1:0]  phase_reg;
    logic        data_ended_reg;
    logic [11:0] code_in_reg;   // raw code c
    logic [11:0] walk_code_reg; // current chain code

    logic [3:0]  eff_min;
    logic [15:0] eff_width;
    logic [11:0] clr_code;
    logic [12:0] new_code;
    logic [3:0]  use_width;
    logic [11:0] cut_mask;
    logic [11:0] cut_code;

    logic        stk_we;
    logic [11:0] stk_waddr;
    logic [7:0]  stk_wdata;
    logic [11:0] stk_raddr;
    logic [7:0]  stk_rdata;
    logic        dict_we;
    logic [11:0] pre_rdata;
    logic [7:0]  suf_rdata;

    always_comb
    begin
        eff_min = min_code_reg;
        if (min_code_reg < 4'd2) eff_min = 4'd2;
        if (min_code_reg > 4'd9) eff_min = 4'd9;
        eff_width = (line_width_reg == 16'd0) ? 16'd1 : line_width_reg;
        clr_code = 12'd1 << eff_min;
        new_code = {1'b0, clr_code} + 13'd2;
        use_width = (code_width_reg < 4'd3 || code_width_reg > 4'(glzw_pkg::CODE_BITS))
                    ? eff_min + 4'd1 : code_width_reg;
        cut_mask = 12'((13'd1 << use_width) - 13'd1);
        cut_code = bit_buffer_reg[11:0] & cut_mask;
    end

    assign sts.phase = phase_reg;
    assign sts.stack_empty = (stack_depth_reg == 13'd0);
    assign sts.enough_bits = ({1'b0, bit_count_reg} >= {2'b0, use_width});
    assign sts.code_is_end = (code_in_reg == clr_code + 12'd1);
    assign sts.code_is_clear = (code_in_reg == clr_code);
    assign sts.walk_more = ({1'b0, walk_code_reg} >= new_code) &&
                           (stack_depth_reg < 13'(glzw_pkg::DICT_DEPTH - 1));
    assign sts.data_ended = data_ended_reg;
    assign bad_code_total = bad_codes_reg;
    assign dict_we = cmd.dec_finish && (next_slot_reg < slot_limit_reg);

    // stack writes: decode start pushes first_pixel/phase1 code, walk pushes suffix,
    // finish pushes root
    always_comb
    begin
        stk_we = 1'b0;
        stk_wdata = 8'd0;
        stk_waddr = stack_depth_reg[11:0];
        stk_raddr = 12'(stack_depth_reg - 13'd1);
        if (stack_depth_reg < 13'(glzw_pkg::DICT_DEPTH))
        begin
            if (cmd.dec_start)
            begin
                if (phase_reg == glzw_pkg::PH_FIRST)
                begin
                    stk_we = 1'b1;
                    stk_wdata = ({1'b0, code_in_reg} >= next_slot_reg) ? 8'd0
                                                                      : code_in_reg[7:0];
                end
                else if ({1'b0, code_in_reg} >= next_slot_reg)
                begin
                    stk_we = 1'b1;
                    stk_wdata = first_pixel_reg;
                end
            end
            else if (cmd.walk_step)
            begin
                stk_we = 1'b1;
                stk_wdata = suf_rdata;
            end
            else if (cmd.dec_finish)
            begin
                stk_we = 1'b1;
                stk_wdata = walk_code_reg[7:0];
            end
        end
    end

    glzw_ram #(.WIDTH(8), .DEPTH(glzw_pkg::DICT_DEPTH)) u_stack (
        .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
        .raddr(stk_raddr), .rdata(stk_rdata)
    );
    glzw_ram #(.WIDTH(12), .DEPTH(glzw_pkg::DICT_DEPTH)) u_prefix (
        .clk(clk), .we(dict_we), .waddr(next_slot_reg[11:0]), .wdata(previous_code_reg),
        .raddr(walk_code_reg), .rdata(pre_rdata)
    );
    glzw_ram #(.WIDTH(8), .DEPTH(glzw_pkg::DICT_DEPTH)) u_suffix (
        .clk(clk), .we(dict_we), .waddr(next_slot_reg[11:0]), .wdata(walk_code_reg[7:0]),
        .raddr(walk_code_reg), .rdata(suf_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_code_reg <= 4'd8;
            line_width_reg <= 16'd640;
            stack_depth_reg <= '0;
            bit_buffer_reg <= '0;
            bit_count_reg <= '0;
            block_remaining_reg <= '0;
            code_width_reg <= 4'd9;
            next_slot_reg <= 13'd258;
            slot_limit_reg <= 13'd512;
            previous_code_reg <= '0;
            first_pixel_reg <= '0;
            row_left_reg <= 16'd640;
            bad_codes_reg <= '0;
            phase_reg <= glzw_pkg::PH_NORMAL;
            data_ended_reg <= 1'b0;
            code_in_reg <= '0;
            walk_code_reg <= '0;
            pixel <= '0;
            status <= '0;
            row_end <= 1'b0;
            partial_row_pixels <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == glzw_pkg::CFG_MIN_CODE) min_code_reg <= cfg_data[3:0];
                else line_width_reg <= cfg_data;
            end
            if (cmd.restart)
            begin
                stack_depth_reg <= '0;
                bit_buffer_reg <= '0;
                bit_count_reg <= '0;
                block_remaining_reg <= '0;
                code_width_reg <= eff_min + 4'd1;
                next_slot_reg <= new_code;
                slot_limit_reg <= 13'd1 << (eff_min + 4'd1);
                previous_code_reg <= '0;
                first_pixel_reg <= '0;
                row_left_reg <= eff_width;
                phase_reg <= glzw_pkg::PH_NORMAL;
                data_ended_reg <= 1'b0;
            end
            if (cmd.push)
            begin
                pixel <= '0;
                row_end <= 1'b0;
                partial_row_pixels <= '0;
                if (phase_reg == glzw_pkg::PH_ENDED) status <= glzw_pkg::ST_ACCEPT;
                else if (data_ended_reg) status <= glzw_pkg::ST_REJECT;
                else if (block_remaining_reg == 8'd0)
                begin
                    status <= glzw_pkg::ST_ACCEPT;
                    if (data_byte == 8'd0) data_ended_reg <= 1'b1;
                    else block_remaining_reg <= data_byte;
                end
                else if (bit_count_reg > 5'd12) status <= glzw_pkg::ST_REJECT;
                else
                begin
                    status <= glzw_pkg::ST_ACCEPT;
                    bit_buffer_reg <= bit_buffer_reg | 20'({12'd0, data_byte} << bit_count_reg);
                    bit_count_reg <= bit_count_reg + 5'd8;
                    block_remaining_reg <= block_remaining_reg - 8'd1;
                end
            end
            if (cmd.pop_req)
            begin
                stack_depth_reg <= stack_depth_reg - 13'd1;
                if (row_left_reg <= 16'd1) row_left_reg <= eff_width;
                else row_left_reg <= row_left_reg - 16'd1;
                row_end <= (row_left_reg <= 16'd1);
            end
            if (cmd.pop_done)
            begin
                pixel <= stk_rdata;
                status <= glzw_pkg::ST_PIXEL;
                partial_row_pixels <= '0;
            end
            if (cmd.emit_status)
            begin
                pixel <= '0;
                row_end <= 1'b0;
                status <= cmd.status_sel;
                partial_row_pixels <= (cmd.status_sel == glzw_pkg::ST_END &&
                                       row_left_reg <= eff_width)
                                      ? eff_width - row_left_reg : 16'd0;
            end
            if (cmd.extract)
            begin
                if (use_width != code_width_reg)
                begin
                    code_width_reg <= eff_min + 4'd1;
                    next_slot_reg <= new_code;
                    slot_limit_reg <= 13'd1 << (eff_min + 4'd1);
                end
                code_in_reg <= cut_code;
                bit_buffer_reg <= bit_buffer_reg >> use_width;
                bit_count_reg <= bit_count_reg - {1'b0, use_width};
            end
            if (cmd.dec_start)
            begin
                if (sts.code_is_end) phase_reg <= glzw_pkg::PH_ENDED;
                else if (sts.code_is_clear)
                begin
                    code_width_reg <= eff_min + 4'd1;
                    next_slot_reg <= new_code;
                    slot_limit_reg <= 13'd1 << (eff_min + 4'd1);
                    phase_reg <= glzw_pkg::PH_FIRST;
                end
                else
                begin
                    if (stk_we) stack_depth_reg <= stack_depth_reg + 13'd1;
                    if (phase_reg == glzw_pkg::PH_FIRST)
                    begin
                        previous_code_reg <= stk_wdata == 8'd0 &&
                            {1'b0, code_in_reg} >= next_slot_reg ? 12'd0 : code_in_reg;
                        first_pixel_reg <= stk_wdata;
                        phase_reg <= glzw_pkg::PH_NORMAL;
                    end
                    else if ({1'b0, code_in_reg} >= next_slot_reg)
                    begin
                        if ({1'b0, code_in_reg} > next_slot_reg && bad_codes_reg != 16'hFFFF)
                            bad_codes_reg <= bad_codes_reg + 16'd1;
                        walk_code_reg <= previous_code_reg;
                    end
                    else walk_code_reg <= code_in_reg;
                end
            end
            if (cmd.walk_step)
            begin
                stack_depth_reg <= stack_depth_reg + 13'd1;
                walk_code_reg <= pre_rdata;
            end
            if (cmd.dec_finish)
            begin
                if (stk_we) stack_depth_reg <= stack_depth_reg + 13'd1;
                first_pixel_reg <= walk_code_reg[7:0];
                previous_code_reg <= code_in_reg;
                if (dict_we)
                begin
                    next_slot_reg <= next_slot_reg + 13'd1;
                    if (next_slot_reg + 13'd1 >= slot_limit_reg &&
                        code_width_reg < 4'(glzw_pkg::CODE_BITS))
                    begin
                        slot_limit_reg <= slot_limit_reg << 1;
                        code_width_reg <= code_width_reg + 4'd1;
                    end
                end
                else if (code_width_reg < 4'(glzw_pkg::CODE_BITS))
                begin
                    slot_limit_reg <= slot_limit_reg << 1;
                    code_width_reg <= code_width_reg + 4'd1;
                end
            end
        end
    end
endmodule
`default_nettype wire

/* rtl/glzw_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
module glzw_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_fire,
    input  wire logic [1:0]          func,
    input  wire logic                out_busy,
    output logic                     in_ready,
    output logic                     out_load,
    input  wire glzw_pkg::glzw_sts_t sts,
    output glzw_pkg::glzw_cmd_t      cmd
);
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_PULL = 4'd1;
    localparam logic [3:0] S_POP = 4'd2;
    localparam logic [3:0] S_CODE = 4'd3;
    localparam logic [3:0] S_WREQ = 4'd4;
    localparam logic [3:0] S_WSTEP = 4'd5;
    localparam logic [3:0] S_WCHK = 4'd6;
    localparam logic [3:0] S_DONE = 4'd7;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign in_ready = (state_reg == S_IDLE) && !out_busy;

    always_comb
    begin
        cmd = '0;
        out_load = 1'b0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (func == glzw_pkg::FUNC_PUSH)
                    begin
                        cmd.push = 1'b1;
                        out_load = 1'b1;
                    end
                    else if (func == glzw_pkg::FUNC_PULL) state_next = S_PULL;
                    else if (func == glzw_pkg::FUNC_RESTART) cmd.restart = 1'b1;
                end
            end
            S_PULL:
            begin
                if (sts.phase == glzw_pkg::PH_ENDED)
                begin
                    cmd.emit_status = 1'b1;
                    cmd.status_sel = glzw_pkg::ST_END;
                    out_load = 1'b1;
                    state_next = S_DONE;
                end
                else if (!sts.stack_empty)
                begin
                    cmd.pop_req = 1'b1;
                    state_next = S_POP;
                end
                else if (!sts.enough_bits)
                begin
                    cmd.emit_status = 1'b1;
                    cmd.status_sel = sts.data_ended ? glzw_pkg::ST_TRUNC : glzw_pkg::ST_NEED;
                    out_load = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.extract = 1'b1;
                    state_next = S_CODE;
                end
            end
            S_POP:
            begin
                cmd.pop_done = 1'b1;
                out_load = 1'b1;
                state_next = S_DONE;
            end
            S_CODE:
            begin
                cmd.dec_start = 1'b1;
                if (sts.code_is_end || sts.code_is_clear ||
                    sts.phase == glzw_pkg::PH_FIRST) state_next = S_PULL;
                else state_next = S_WCHK;
            end
            S_WCHK:
            begin
                if (sts.walk_more) state_next = S_WREQ;
                else
                begin
                    cmd.dec_finish = 1'b1;
                    state_next = S_PULL;
                end
            end
            // dictionary read of the chain code is in flight
            S_WREQ: state_next = S_WSTEP;
            S_WSTEP:
            begin
                cmd.walk_step = 1'b1;
                state_next = S_WCHK;
            end
            S_DONE: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) state_reg <= S_IDLE;
        else state_reg <= state_next;
    end
endmodule
`default_nettype wire

/* dv/tb_gif_lzw_decoder.sv */
`timescale 1ns / 1ps
module tb_gif_lzw_decoder;
    import glzw_pkg::*;

    localparam logic [1:0] FUNC_NOP = 2'd3;
    localparam int STALL_LIMIT = 20000;
    localparam int ITEM_TARGET = 1100;

    // pixel lowest, matching the result word layout
    typedef struct packed {
        logic [15:0] bad_total;
        logic [15:0] partial;
        logic        row_end;
        logic [2:0]  status;
        logic [7:0]  pixel;
    } px_word_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [15:0] cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;

    gif_lzw_decoder DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    logic [9:0]  word_q[$];     // {data_byte, func}
    px_word_t    pending_px[$];
    int          src_idle_pct;
    int          snk_idle_pct;
    int          errors;
    int          n_words;
    int          n_checked;
    int          n_pixels;
    int          n_images;
    int          stall_cycles;

    // decoder mirror
    int unsigned    dm_min;
    int unsigned    dm_lw;
    bit [11:0]      dm_prefix[DICT_DEPTH];
    bit [7:0]       dm_suffix[DICT_DEPTH];
    bit [7:0]       dm_stack[DICT_DEPTH];
    int unsigned    dm_depth;
    int unsigned    dm_bits;
    int unsigned    dm_nbits;
    int unsigned    dm_blk_left;
    int unsigned    dm_width;
    int unsigned    dm_next;
    int unsigned    dm_limit;
    int unsigned    dm_prev;
    int unsigned    dm_first;
    int unsigned    dm_row_left;
    int unsigned    dm_bad;
    int unsigned    dm_phase;
    bit             dm_ended;

    // encoder scratch
    bit [7:0]       code_bytes[$];
    bit [7:0]       stream[$];
    int unsigned    enc_acc;
    int unsigned    enc_n;

    function automatic int unsigned eff_min();
        if (dm_min < 2) return 2;
        if (dm_min > 9) return 9;
        return dm_min;
    endfunction

    function automatic int unsigned eff_lw();
        return (dm_lw == 0) ? 1 : dm_lw;
    endfunction

    function automatic void reload_width();
        dm_width = eff_min() + 1;
        dm_next = (1 << eff_min()) + 2;
        dm_limit = 1 << dm_width;
    endfunction

    function automatic void restart_dec();
        dm_depth = 0;
        dm_bits = 0;
        dm_nbits = 0;
        dm_blk_left = 0;
        reload_width();
        dm_prev = 0;
        dm_first = 0;
        dm_row_left = eff_lw();
        dm_phase = PH_NORMAL;
        dm_ended = 0;
    endfunction

    function automatic void stack_px(int unsigned v);
        if (dm_depth < DICT_DEPTH) begin
            dm_stack[dm_depth] = v[7:0];
            dm_depth++;
        end
    endfunction

    function automatic px_word_t mk_word(int unsigned pix, logic [2:0] st, bit rend,
                                         int unsigned part);
        px_word_t r;
        r.pixel = pix[7:0];
        r.status = st;
        r.row_end = rend;
        r.partial = part[15:0];
        r.bad_total = dm_bad[15:0];
        return r;
    endfunction

    function automatic void decode_one(int unsigned c);
        int unsigned newc;
        int unsigned code;
        newc = (1 << eff_min()) + 2;
        code = c;
        if (dm_phase == PH_FIRST) begin
            if (code >= dm_next) code = 0;
            dm_prev = code & 12'hFFF;
            dm_first = code & 8'hFF;
            stack_px(code);
            dm_phase = PH_NORMAL;
            return;
        end
        // KwKwK and out-of-range codes both replay the previous string
        if (code >= dm_next) begin
            if (code > dm_next && dm_bad < 16'hFFFF) dm_bad++;
            code = dm_prev;
            stack_px(dm_first);
        end
        while (code >= newc && dm_depth < DICT_DEPTH - 1) begin
            stack_px(dm_suffix[code % DICT_DEPTH]);
            code = dm_prefix[code % DICT_DEPTH];
        end
        stack_px(code);
        dm_first = code & 8'hFF;
        if (dm_next < dm_limit) begin
            dm_suffix[dm_next % DICT_DEPTH] = dm_first[7:0];
            dm_prefix[dm_next % DICT_DEPTH] = dm_prev[11:0];
            dm_next++;
        end
        dm_prev = c & 12'hFFF;
        if (dm_next >= dm_limit && dm_width < CODE_BITS) begin
            dm_limit = dm_limit << 1;
            dm_width++;
        end
    endfunction

    function automatic px_word_t pull_px();
        int unsigned c;
        int unsigned clr;
        int unsigned pix;
        int unsigned lw;
        bit rend;
        forever begin
            if (dm_phase == PH_ENDED) begin
                lw = eff_lw();
                return mk_word(0, ST_END, 0, (dm_row_left <= lw) ? lw - dm_row_left : 0);
            end
            if (dm_depth > 0) begin
                dm_depth--;
                pix = dm_stack[dm_depth];
                rend = 0;
                if (dm_row_left <= 1) begin
                    rend = 1;
                    dm_row_left = eff_lw();
                end else begin
                    dm_row_left--;
                end
                return mk_word(pix, ST_PIXEL, rend, 0);
            end
            if (dm_width < 3 || dm_width > CODE_BITS) reload_width();
            if (dm_nbits < dm_width) return mk_word(0, dm_ended ? ST_TRUNC : ST_NEED, 0, 0);
            c = dm_bits & ((1 << dm_width) - 1);
            dm_bits = dm_bits >> dm_width;
            dm_nbits -= dm_width;
            clr = 1 << eff_min();
            if (c == clr + 1) begin
                dm_phase = PH_ENDED;
            end else if (c == clr) begin
                reload_width();
                dm_phase = PH_FIRST;
            end else begin
                decode_one(c);
            end
        end
    endfunction

    function automatic px_word_t push_dec(int unsigned b);
        if (dm_phase == PH_ENDED) return mk_word(0, ST_ACCEPT, 0, 0);
        if (dm_ended) return mk_word(0, ST_REJECT, 0, 0);
        if (dm_blk_left == 0) begin
            if (b == 0) dm_ended = 1;
            else dm_blk_left = b;
            return mk_word(0, ST_ACCEPT, 0, 0);
        end
        if (dm_nbits + 8 > BUF_BITS) return mk_word(0, ST_REJECT, 0, 0);
        dm_bits = (dm_bits | (b << dm_nbits)) & ((1 << BUF_BITS) - 1);
        dm_nbits += 8;
        dm_blk_left--;
        return mk_word(0, ST_ACCEPT, 0, 0);
    endfunction

    // queue one word and, for push and pull, its predicted result; returns the predicted status (7 for other words)
    function automatic logic [2:0] send(logic [1:0] func, logic [7:0] b);
        px_word_t r;
        word_q.push_back({b, func});
        n_words++;
        if (func == FUNC_PUSH) begin
            r = push_dec(b);
        end else if (func == FUNC_PULL) begin
            r = pull_px();
            if (r.status == ST_PIXEL) n_pixels++;
        end else begin
            if (func == FUNC_RESTART) restart_dec();
            return 3'd7;
        end
        pending_px.push_back(r);
        return r.status;
    endfunction

    function automatic void enc_put(int unsigned code, int unsigned w);
        enc_acc = enc_acc | (code << enc_n);
        enc_n += w;
        while (enc_n >= 8) begin
            code_bytes.push_back(enc_acc[7:0]);
            enc_acc = enc_acc >> 8;
            enc_n -= 8;
        end
    endfunction

    // random LZW code sequence at the current minimum code size, split into sub-blocks
    function automatic void build_stream();
        int unsigned clr;
        int unsigned w;
        int unsigned ns;
        int unsigned lim;
        int unsigned ncodes;
        int unsigned code;
        int unsigned r;
        int unsigned top;
        int unsigned i;
        int unsigned n;
        bit first;
        bit bad;
        code_bytes.delete();
        stream.delete();
        enc_acc = 0;
        enc_n = 0;
        clr = 1 << eff_min();
        w = eff_min() + 1;
        ns = clr + 2;
        lim = 1 << w;
        first = 0;
        if ($urandom_range(0, 3) != 0) begin
            enc_put(clr, w);
            first = 1;
        end
        ncodes = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150)
                                             : $urandom_range(3, 30);
        repeat (ncodes) begin
            r = $urandom_range(0, 99);
            top = (1 << w) - 1;
            if (!first && r < 4) begin
                // clear goes out at the width in use, then the width drops back
                enc_put(clr, w);
                w = eff_min() + 1;
                ns = clr + 2;
                lim = 1 << w;
                first = 1;
            end else if (first) begin
                code = (r < 10) ? $urandom_range(ns, top) : $urandom_range(0, clr - 1);
                enc_put(code, w);
                first = 0;
            end else begin
                bad = 0;
                if (r < 12 && ns <= top) code = ns;
                else if (r < 17 && ns + 1 <= top) begin
                    code = $urandom_range(ns + 1, top);
                    bad = 1;
                end
                else code = $urandom_range(0, ns - 1);
                if (code == clr || code == clr + 1) code = $urandom_range(0, clr - 1);
                enc_put(code, w);
                if (ns < lim) ns++;
                if (ns >= lim && w < CODE_BITS) begin
                    lim = lim << 1;
                    w++;
                end
                // a code past the next slot would chain into unwritten entries later
                if (bad) begin
                    enc_put(clr, w);
                    w = eff_min() + 1;
                    ns = clr + 2;
                    lim = 1 << w;
                    first = 1;
                end
            end
        end
        if ($urandom_range(0, 4) != 0) enc_put(clr + 1, w);
        if (enc_n > 0) code_bytes.push_back(enc_acc[7:0]);
        i = 0;
        while (i < code_bytes.size()) begin
            n = ($urandom_range(0, 9) == 0) ? 255 : $urandom_range(1, 8);
            if (n > code_bytes.size() - i) n = code_bytes.size() - i;
            stream.push_back(n[7:0]);
            repeat (n) begin
                stream.push_back(code_bytes[i]);
                i++;
            end
        end
        if ($urandom_range(0, 3) != 0) stream.push_back(8'd0);
    endfunction

    // feed one stream, pulling pixels and pushing bytes as the decoder asks
    function automatic void decode_image();
        int unsigned idx;
        int unsigned steps;
        logic [2:0] st;
        bit done;
        idx = 0;
        steps = 0;
        done = 0;
        build_stream();
        while (!done && steps < 500) begin
            if (idx < stream.size() && $urandom_range(0, 7) == 0) begin
                st = send(FUNC_PUSH, stream[idx]);
                if (st == ST_ACCEPT || dm_ended) idx++;
            end else if ($urandom_range(0, 39) == 0) begin
                void'(send(FUNC_NOP, 8'($urandom_range(0, 255))));
            end else begin
                st = send(FUNC_PULL, 8'($urandom_range(0, 255)));
                if (st == ST_NEED) begin
                    if (idx < stream.size()) begin
                        void'(send(FUNC_PUSH, stream[idx]));
                        idx++;
                    end else begin
                        done = 1;
                    end
                end else if (st == ST_END || st == ST_TRUNC) begin
                    done = 1;
                end
            end
            steps++;
        end
        void'(send(FUNC_PUSH, 8'($urandom_range(0, 255))));
        void'(send(FUNC_PULL, 8'($urandom_range(0, 255))));
        void'(send(FUNC_RESTART, 8'($urandom_range(0, 255))));
        n_images++;
    endfunction

    task automatic drain();
        while (word_q.size() > 0 || pending_px.size() > 0 || s_axis_tvalid)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_cfg(logic idx, logic [15:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_MIN_CODE) dm_min = val[3:0];
        else dm_lw = val;
    endtask

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // word driver
    always @(posedge clk or negedge rst_n) begin
        logic [9:0] nxt;
        if (!rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            s_axis_tuser <= '0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (word_q.size() > 0 && $urandom_range(0, 99) >= src_idle_pct) begin
                nxt = word_q.pop_front();
                s_axis_tuser <= nxt[1:0];
                s_axis_tdata <= nxt[9:2];
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result monitor and stall watchdog
    always @(posedge clk or negedge rst_n) begin
        px_word_t got;
        px_word_t want;
        if (!rst_n) begin
            m_axis_tready <= 1'b0;
            stall_cycles <= 0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = {m_axis_tdata[39:24], m_axis_tdata[23:8], m_axis_tlast, m_axis_tuser,
                       m_axis_tdata[7:0]};
                if (pending_px.size() == 0) begin
                    $error("unexpected result word %h", got);
                    errors++;
                end else begin
                    want = pending_px.pop_front();
                    n_checked++;
                    if (got.pixel !== want.pixel) begin
                        $error("pixel exp %0d got %0d", want.pixel, got.pixel);
                        errors++;
                    end
                    if (got.status !== want.status) begin
                        $error("status exp %0d got %0d", want.status, got.status);
                        errors++;
                    end
                    if (got.row_end !== want.row_end) begin
                        $error("row_end exp %0d got %0d", want.row_end, got.row_end);
                        errors++;
                    end
                    if (got.partial !== want.partial) begin
                        $error("partial_row_pixels exp %0d got %0d", want.partial,
                               got.partial);
                        errors++;
                    end
                    if (got.bad_total !== want.bad_total) begin
                        $error("bad_code_total exp %0d got %0d", want.bad_total,
                               got.bad_total);
                        errors++;
                    end
                end
            end
        end
    end

    initial begin
        int unsigned mins[12];
        int unsigned widths[12];
        int sel;
        int mode;
        mins = '{2, 9, 0, 15, 3, 5, 8, 4, 7, 6, 1, 10};
        widths = '{1, 65535, 0, 3, 7, 640, 16, 5, 2, 33, 4, 12};
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = 1'b0;
        cfg_data = '0;
        src_idle_pct = 12;
        snk_idle_pct = 65;
        errors = 0;
        n_words = 0;
        n_checked = 0;
        n_pixels = 0;
        n_images = 0;
        sel = 0;
        mode = 0;
        dm_min = 8;
        dm_lw = 640;
        dm_bad = 0;
        restart_dec();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: empty pulls, zero-length block, overflow, noise, restart
        void'(send(FUNC_PULL, 8'h00));
        void'(send(FUNC_PUSH, 8'h00));
        void'(send(FUNC_PULL, 8'hFF));
        void'(send(FUNC_PUSH, 8'hA5));
        void'(send(FUNC_NOP, 8'h5A));
        void'(send(FUNC_RESTART, 8'h00));
        void'(send(FUNC_PUSH, 8'd4));
        void'(send(FUNC_PUSH, 8'hFF));
        void'(send(FUNC_PUSH, 8'hFF));
        void'(send(FUNC_PUSH, 8'h00));
        void'(send(FUNC_PUSH, 8'hFF));
        repeat (6) void'(send(FUNC_PULL, 8'h00));
        void'(send(FUNC_RESTART, 8'hFF));
        drain();

        while (n_words < ITEM_TARGET) begin
            if (mode == 0 && n_words > 400) begin
                drain();
                mode = 1;
                src_idle_pct = 65;
                snk_idle_pct = 12;
            end else if (mode == 1 && n_words > 750) begin
                drain();
                mode = 2;
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            if (n_images < 3 || $urandom_range(0, 2) == 0) begin
                drain();
                write_cfg(CFG_MIN_CODE, 16'(mins[sel % 12]));
                write_cfg(CFG_LINE_WIDTH, 16'(($urandom_range(0, 3) == 0) ?
                          $urandom_range(1, 65535) : widths[sel % 12]));
                sel++;
                void'(send(FUNC_RESTART, 8'($urandom_range(0, 255))));
            end
            decode_image();
        end
        drain();

        $display("covered %0d words over %0d streams, %0d results checked, %0d pixels",
                 n_words, n_images, n_checked, n_pixels);
        $display("%0d configuration settings, code sizes 2..9 plus saturating values", sel);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
